@@ hdl/assert_macros.svh @@
// assertion macros used by the port checker in hdl/xet_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/xet_pkg.sv @@
// package: types and constants of the xml event tokenizer
`timescale 1ns / 1ps
package xet_pkg;

    localparam logic [15:0] CH_LT    = 16'h003C;
    localparam logic [15:0] CH_SLASH = 16'h002F;
    localparam logic [15:0] CH_GT    = 16'h003E;
    localparam logic [15:0] CH_EQ    = 16'h003D;
    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_QUOTE = 16'h0022;
    localparam logic [15:0] MARKER_RESET = 16'hFEFF;

    localparam logic [1:0] REG_MARKER = 2'd0;

    localparam logic [2:0] EV_DOCSTART = 3'd0;
    localparam logic [2:0] EV_ESTART   = 3'd1;
    localparam logic [2:0] EV_ATTR     = 3'd2;
    localparam logic [2:0] EV_TEXT     = 3'd3;
    localparam logic [2:0] EV_EEND     = 3'd4;
    localparam logic [2:0] EV_FMT      = 3'd5;
    localparam logic [2:0] EV_NOTUNI   = 3'd6;
    localparam logic [2:0] EV_DOCEND   = 3'd7;

    typedef enum logic [1:0] {
        DOC_AWAIT,
        DOC_RUN,
        DOC_REJECT,
        DOC_DONE
    } doc_status_t;

    typedef enum logic [2:0] {
        MODE_ESTART,
        MODE_ANAME,
        MODE_AVALUE,
        MODE_TEXT,
        MODE_EEND
    } parse_mode_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_NAME,
        CTL_VALUE,
        CTL_EMPTY
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic       take;      // input word accepted
        logic       clr_name;  // token buffers clear
        logic       rd_name;   // read name entry at rd_idx
        logic       rd_value;  // read value entry at rd_idx
        logic [4:0] rd_idx;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       fire;      // accepted word raised an event
        logic [2:0] kind;
        logic [5:0] name_len;  // characters of the name part
        logic [5:0] value_len; // characters of the value part
        logic       use_value; // first part comes from value store
        logic       chain_estart; // empty element start follows this event
    } dp_evt_t;

endpackage

@@ hdl/xet_ram.sv @@
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module xet_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/xet_datapath.sv @@
// datapath: parse modes, token buffers and event detection
`timescale 1ns / 1ps
module xet_datapath import xet_pkg::*; #(
    parameter int NAME_DEPTH  = 32,
    parameter int VALUE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] marker,
    input  logic [15:0] code_unit,
    input  logic        end_of_document,
    input  dp_cmd_t     cmd,
    output dp_evt_t     evt,
    output logic [15:0] rd_data
);
    localparam int NAW = $clog2(NAME_DEPTH);
    localparam int VAW = $clog2(VALUE_DEPTH);
    localparam logic [5:0] NDEP = 6'(NAME_DEPTH);
    localparam logic [5:0] VDEP = 6'(VALUE_DEPTH);

    doc_status_t doc_reg, doc_next;
    parse_mode_t mode_reg, mode_next;
    logic [5:0]  ncnt_reg, ncnt_next, vcnt_reg, vcnt_next;
    logic [15:0] prev_reg, prev_next;
    logic        quote_reg, quote_next, kept_reg, kept_next;
    logic        nwe, vwe, rsel_reg;
    logic [15:0] nrd, vrd;
    logic        c_sp, c_gt;
    logic [15:0] c;

    assign c    = code_unit;
    assign c_sp = (c == CH_SPACE);
    assign c_gt = (c == CH_GT);

    xet_ram #(.WIDTH(16), .DEPTH(NAME_DEPTH)) u_name (
        .clk(clk), .we(nwe), .waddr(ncnt_reg[NAW-1:0]), .wdata(c),
        .raddr(cmd.rd_idx[NAW-1:0]), .rdata(nrd)
    );
    xet_ram #(.WIDTH(16), .DEPTH(VALUE_DEPTH)) u_value (
        .clk(clk), .we(vwe), .waddr(vcnt_reg[VAW-1:0]), .wdata(c),
        .raddr(cmd.rd_idx[VAW-1:0]), .rdata(vrd)
    );

    assign rd_data = rsel_reg ? vrd : nrd;

    always_comb
    begin
        doc_next   = doc_reg;
        mode_next  = mode_reg;
        ncnt_next  = ncnt_reg;
        vcnt_next  = vcnt_reg;
        prev_next  = prev_reg;
        quote_next = quote_reg;
        kept_next  = kept_reg;
        nwe        = 1'b0;
        vwe        = 1'b0;
        evt        = '0;
        evt.kind   = EV_DOCSTART;
        if (cmd.take)
        begin
            unique case (doc_reg)
                DOC_AWAIT:
                begin
                    evt.fire = 1'b1;
                    if (!end_of_document && c == marker)
                    begin
                        evt.kind = EV_DOCSTART;
                        doc_next = DOC_RUN;
                    end
                    else
                    begin
                        evt.kind = EV_NOTUNI;
                        doc_next = DOC_REJECT;
                    end
                end
                DOC_RUN:
                begin
                    if (end_of_document)
                    begin
                        evt.fire = 1'b1;
                        evt.kind = EV_DOCEND;
                        doc_next = DOC_DONE;
                        ncnt_next = '0; vcnt_next = '0; prev_next = '0;
                        kept_next = 1'b0; quote_next = 1'b0;
                    end
                    else if (c >= 16'h0020)
                    begin
                        // text mode with pending '<' folds into element start, or element end on '/'
                        logic estart_now;
                        estart_now = 1'b0;
                        unique case (mode_reg)
                            MODE_TEXT:
                            begin
                                if (prev_reg == CH_LT)
                                begin
                                    ncnt_next = '0; vcnt_next = '0; prev_next = '0;
                                    kept_next = 1'b0; quote_next = 1'b0;
                                    if (c != CH_SLASH)
                                    begin
                                        evt.fire = (vcnt_reg != '0);
                                        evt.kind = EV_FMT;
                                        evt.value_len = vcnt_reg;
                                        evt.use_value = 1'b1;
                                        mode_next = MODE_ESTART;
                                        // buffers are empty here
                                        if (!c_sp && !c_gt)
                                        begin
                                            nwe = 1'b1;
                                            ncnt_next = 6'd1;
                                            kept_next = 1'b1;
                                            prev_next = c;
                                        end
                                        else if (c_gt)
                                        begin
                                            estart_now = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        evt.fire = (vcnt_reg != '0);
                                        evt.kind = EV_TEXT;
                                        evt.value_len = vcnt_reg;
                                        evt.use_value = 1'b1;
                                        mode_next = MODE_EEND;
                                    end
                                end
                                else if (c == CH_LT)
                                begin
                                    prev_next = c;
                                end
                                else
                                begin
                                    if (vcnt_reg < VDEP)
                                    begin
                                        vwe = 1'b1;
                                        vcnt_next = vcnt_reg + 6'd1;
                                    end
                                    prev_next = c;
                                end
                            end
                            MODE_ESTART:
                            begin
                                if (c_sp && ncnt_reg == '0)
                                begin
                                end
                                else if (c_sp || c_gt)
                                begin
                                    evt.fire = 1'b1;
                                    evt.kind = EV_ESTART;
                                    evt.name_len = ncnt_reg;
                                    if (c_gt && prev_reg == CH_SLASH && ncnt_reg > 6'd1
                                        && kept_reg)
                                    begin
                                        evt.name_len = ncnt_reg - 6'd1;
                                    end
                                    mode_next = c_sp ? MODE_ANAME : MODE_TEXT;
                                    ncnt_next = '0; vcnt_next = '0; prev_next = '0;
                                    kept_next = 1'b0; quote_next = 1'b0;
                                end
                                else
                                begin
                                    kept_next = (ncnt_reg < NDEP);
                                    if (ncnt_reg < NDEP)
                                    begin
                                        nwe = 1'b1;
                                        ncnt_next = ncnt_reg + 6'd1;
                                    end
                                    prev_next = c;
                                end
                            end
                            MODE_ANAME:
                            begin
                                if (c_sp)
                                begin
                                end
                                else if (c == CH_EQ)
                                begin
                                    vcnt_next = '0;
                                    quote_next = 1'b0;
                                    mode_next = MODE_AVALUE;
                                end
                                else if (c_gt)
                                begin
                                    ncnt_next = '0; vcnt_next = '0; prev_next = '0;
                                    kept_next = 1'b0; quote_next = 1'b0;
                                    mode_next = MODE_TEXT;
                                end
                                else
                                begin
                                    kept_next = (ncnt_reg < NDEP);
                                    if (ncnt_reg < NDEP)
                                    begin
                                        nwe = 1'b1;
                                        ncnt_next = ncnt_reg + 6'd1;
                                    end
                                    prev_next = c;
                                end
                            end
                            MODE_AVALUE:
                            begin
                                if (!quote_reg)
                                begin
                                    quote_next = (c == CH_QUOTE);
                                end
                                else if (c == CH_QUOTE)
                                begin
                                    evt.fire = 1'b1;
                                    evt.kind = EV_ATTR;
                                    evt.name_len = ncnt_reg;
                                    evt.value_len = vcnt_reg;
                                    ncnt_next = '0; vcnt_next = '0; prev_next = '0;
                                    kept_next = 1'b0; quote_next = 1'b0;
                                    mode_next = MODE_ANAME;
                                end
                                else
                                begin
                                    if (vcnt_reg < VDEP)
                                    begin
                                        vwe = 1'b1;
                                        vcnt_next = vcnt_reg + 6'd1;
                                    end
                                    prev_next = c;
                                end
                            end
                            MODE_EEND:
                            begin
                                if (c_sp)
                                begin
                                end
                                else if (c_gt)
                                begin
                                    evt.fire = (ncnt_reg != '0);
                                    evt.kind = EV_EEND;
                                    evt.name_len = ncnt_reg;
                                    ncnt_next = '0; vcnt_next = '0; prev_next = '0;
                                    kept_next = 1'b0; quote_next = 1'b0;
                                    mode_next = MODE_TEXT;
                                end
                                else
                                begin
                                    kept_next = (ncnt_reg < NDEP);
                                    if (ncnt_reg < NDEP)
                                    begin
                                        nwe = 1'b1;
                                        ncnt_next = ncnt_reg + 6'd1;
                                    end
                                    prev_next = c;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        // "<>": format error if text is pending, then empty element start
                        if (estart_now)
                        begin
                            evt.fire = 1'b1;
                            mode_next = MODE_TEXT;
                            if (vcnt_reg == '0)
                            begin
                                evt.kind = EV_ESTART;
                                evt.name_len = '0;
                                evt.value_len = '0;
                                evt.use_value = 1'b0;
                            end
                            else
                            begin
                                evt.chain_estart = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            doc_reg   <= DOC_AWAIT;
            mode_reg  <= MODE_TEXT;
            ncnt_reg  <= '0;
            vcnt_reg  <= '0;
            prev_reg  <= '0;
            quote_reg <= 1'b0;
            kept_reg  <= 1'b0;
            rsel_reg  <= 1'b0;
        end
        else
        begin
            doc_reg   <= doc_next;
            mode_reg  <= mode_next;
            ncnt_reg  <= ncnt_next;
            vcnt_reg  <= vcnt_next;
            prev_reg  <= prev_next;
            quote_reg <= quote_next;
            kept_reg  <= kept_next;
            rsel_reg  <= cmd.rd_value;
        end
    end
endmodule

@@ hdl/xet_controller.sv @@
// controller: accepts words and sequences event output
`timescale 1ns / 1ps
module xet_controller import xet_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  dp_evt_t     evt,
    output dp_cmd_t     cmd,
    input  logic [15:0] rd_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [15:0] char_value,
    output logic        char_present,
    output logic        char_part,
    output logic        last_of_event
);
    ctl_state_t state_reg, state_next;
    logic [2:0] kind_reg, kind_next;
    logic [5:0] nlen_reg, nlen_next, vlen_reg, vlen_next, idx_reg, idx_next;
    logic       usev_reg, usev_next;
    logic       chain_reg, chain_next;
    logic       ov_reg, ov_next, pend_reg, pend_next;
    logic       part_reg, part_next, pres_reg, pres_next, last_reg, last_next;
    logic [2:0] okind_reg, okind_next;
    logic       slot_free;

    // pend: ram data of the word in the output register arrives this cycle
    assign slot_free = !ov_reg || !out_stall;
    assign in_stall  = (state_reg != CTL_IDLE) || pend_reg || !slot_free;

    assign out_valid     = ov_reg;
    assign event_kind    = okind_reg;
    assign char_present  = pres_reg;
    assign char_part     = part_reg;
    assign last_of_event = last_reg;

    logic [15:0] cval_reg;
    assign char_value = pend_reg ? rd_data : cval_reg;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        nlen_next  = nlen_reg;
        vlen_next  = vlen_reg;
        idx_next   = idx_reg;
        usev_next  = usev_reg;
        chain_next = chain_reg;
        ov_next    = ov_reg && out_stall;
        pend_next  = 1'b0;
        part_next  = part_reg;
        pres_next  = pres_reg;
        last_next  = last_reg;
        okind_next = okind_reg;
        cmd        = '0;
        cmd.take   = in_valid && !in_stall;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (cmd.take && evt.fire)
                begin
                    kind_next  = evt.kind;
                    nlen_next  = evt.name_len;
                    vlen_next  = evt.value_len;
                    usev_next  = evt.use_value;
                    chain_next = evt.chain_estart;
                    idx_next   = '0;
                    if (evt.name_len == '0 && evt.value_len == '0)
                    begin
                        state_next = CTL_EMPTY;
                    end
                    else if (evt.use_value || evt.name_len == '0)
                    begin
                        state_next = CTL_VALUE;
                    end
                    else
                    begin
                        state_next = CTL_NAME;
                    end
                end
            end
            CTL_EMPTY:
            begin
                if (slot_free && !pend_reg)
                begin
                    ov_next = 1'b1; okind_next = kind_reg; pres_next = 1'b0;
                    part_next = 1'b0; last_next = 1'b1;
                    state_next = CTL_IDLE;
                end
            end
            CTL_NAME:
            begin
                if (slot_free)
                begin
                    cmd.rd_name = 1'b1;
                    cmd.rd_idx  = idx_reg[4:0];
                    ov_next = 1'b1; pend_next = 1'b1; okind_next = kind_reg;
                    pres_next = 1'b1; part_next = 1'b0;
                    last_next = (idx_reg + 6'd1 == nlen_reg) && (vlen_reg == '0);
                    if (idx_reg + 6'd1 == nlen_reg)
                    begin
                        idx_next = '0;
                        state_next = (vlen_reg == '0) ? CTL_IDLE : CTL_VALUE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
            end
            CTL_VALUE:
            begin
                if (slot_free)
                begin
                    cmd.rd_value = 1'b1;
                    cmd.rd_idx   = idx_reg[4:0];
                    ov_next = 1'b1; pend_next = 1'b1; okind_next = kind_reg;
                    pres_next = 1'b1;
                    part_next = !usev_reg;
                    last_next = (idx_reg + 6'd1 == vlen_reg);
                    if (idx_reg + 6'd1 == vlen_reg)
                    begin
                        if (chain_reg)
                        begin
                            // empty element start after the format error
                            kind_next  = EV_ESTART;
                            chain_next = 1'b0;
                            state_next = CTL_EMPTY;
                        end
                        else
                        begin
                            state_next = CTL_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
        end
    end

    // hold ram data once captured so a stalled word stays stable
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        nlen_reg  <= nlen_next;
        vlen_reg  <= vlen_next;
        idx_reg   <= idx_next;
        usev_reg  <= usev_next;
        chain_reg <= chain_next;
        part_reg  <= part_next;
        pres_reg  <= pres_next;
        last_reg  <= last_next;
        okind_reg <= okind_next;
        if (pend_reg)
        begin
            cval_reg <= rd_data;
        end
        else if (!pres_next || !ov_reg || !out_stall)
        begin
            cval_reg <= '0;
        end
    end
endmodule

@@ hdl/xml_event_tokenizer.sv @@
// top level of the xml event tokenizer
// event words pass the controller state register and then the output register
// throughput: one character word per cycle while no event fires and output is free
// events hold input while their words and any "<>" start after text are read out
// reset: asynchronous active low; awaits the marker, text mode, buffers empty
`timescale 1ns / 1ps
module xml_event_tokenizer import xet_pkg::*; #(
    parameter int NAME_DEPTH  = 32,
    parameter int VALUE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        end_of_document,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [15:0] char_value,
    output logic        char_present,
    output logic        char_part,
    output logic        last_of_event
);
    logic [15:0] marker_reg;
    dp_cmd_t     cmd;
    dp_evt_t     evt;
    logic [15:0] rd_data;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MARKER) ? {16'h0000, marker_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= MARKER_RESET;
        end
        else if (psel && penable && pwrite && paddr == REG_MARKER)
        begin
            marker_reg <= pwdata[15:0];
        end
    end

    xet_datapath #(.NAME_DEPTH(NAME_DEPTH), .VALUE_DEPTH(VALUE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .marker(marker_reg), .code_unit(code_unit),
        .end_of_document(end_of_document), .cmd(cmd), .evt(evt), .rd_data(rd_data)
    );

    xet_controller u_ctl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .evt(evt), .cmd(cmd), .rd_data(rd_data), .out_valid(out_valid),
        .out_stall(out_stall), .event_kind(event_kind), .char_value(char_value),
        .char_present(char_present), .char_part(char_part),
        .last_of_event(last_of_event)
    );
endmodule

@@ hdl/xet_checker.sv @@
// checker on the top level ports, bound to the tokenizer
`timescale 1ns / 1ps
`include "assert_macros.svh"
module xet_sva (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       char_present,
    input logic       char_part,
    input logic       last_of_event,
    input logic [2:0] event_kind
);
    `ASSERT_IMPLY(a_empty_is_last, clk, rst_n, out_valid && !char_present, last_of_event)
    `ASSERT_IMPLY(a_empty_part, clk, rst_n, out_valid && !char_present, !char_part)
    `ASSERT_NEXT(a_kind_hold, clk, rst_n, out_valid && out_stall, $stable(event_kind))
endmodule

bind xml_event_tokenizer xet_sva u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .char_present(char_present), .char_part(char_part),
    .last_of_event(last_of_event), .event_kind(event_kind)
);

@@ dv/xet_checker.sv @@
// checker: predicts tokenizer events from accepted words and compares results
`timescale 1ns / 1ps
module xet_checker import xet_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        end_of_document,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  event_kind,
    input  logic [15:0] char_value,
    input  logic        char_present,
    input  logic        char_part,
    input  logic        last_of_event,
    output int          fail_count,
    output int          pending
);

    localparam int NDEPTH = 32;
    localparam int VDEPTH = 32;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] ch;
        logic        present;
        logic        part;
        logic        last;
    } event_word_t;

    event_word_t   expected_words[$];
    logic [15:0]   marker;
    doc_status_t   doc_st;
    parse_mode_t   mode;
    logic [15:0]   name_buf[NDEPTH];
    logic [15:0]   value_buf[VDEPTH];
    int            name_len;
    int            value_len;
    logic [15:0]   prev_ch;
    logic          quote_open;
    logic          prev_kept;

    function automatic void push_word(logic [2:0] k, logic [15:0] c, logic pr, logic pt);
        event_word_t w;
        w.kind = k;
        w.ch = c;
        w.present = pr;
        w.part = pt;
        w.last = 1'b0;
        expected_words.push_back(w);
    endfunction

    function automatic void emit_event(logic [2:0] k, int na, int nb, logic a_from_value);
        if (na == 0 && nb == 0)
            push_word(k, 16'h0000, 1'b0, 1'b0);
        else
        begin
            for (int i = 0; i < na; i++)
                push_word(k, a_from_value ? value_buf[i] : name_buf[i], 1'b1, 1'b0);
            for (int i = 0; i < nb; i++)
                push_word(k, value_buf[i], 1'b1, 1'b1);
        end
        expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    function automatic void clear_tokens();
        name_len = 0;
        value_len = 0;
        prev_ch = 16'h0000;
        prev_kept = 1'b0;
        quote_open = 1'b0;
    endfunction

    function automatic void keep_name(logic [15:0] c);
        prev_kept = name_len < NDEPTH;
        if (prev_kept)
        begin
            name_buf[name_len] = c;
            name_len++;
        end
        prev_ch = c;
    endfunction

    function automatic void keep_value(logic [15:0] c);
        if (value_len < VDEPTH)
        begin
            value_buf[value_len] = c;
            value_len++;
        end
        prev_ch = c;
    endfunction

    function automatic void element_start(logic [15:0] c);
        if (c == CH_SPACE && name_len == 0)
            return;
        if (c == CH_SPACE)
        begin
            emit_event(EV_ESTART, name_len, 0, 1'b0);
            clear_tokens();
            mode = MODE_ANAME;
        end
        else if (c == CH_GT && prev_ch == CH_SLASH && name_len > 1)
        begin
            emit_event(EV_ESTART, name_len - (prev_kept ? 1 : 0), 0, 1'b0);
            clear_tokens();
            mode = MODE_TEXT;
        end
        else if (c == CH_GT)
        begin
            emit_event(EV_ESTART, name_len, 0, 1'b0);
            clear_tokens();
            mode = MODE_TEXT;
        end
        else
            keep_name(c);
    endfunction

    function automatic void tokenize(logic [15:0] c, logic eod);
        if (doc_st == DOC_AWAIT)
        begin
            if (!eod && c == marker)
            begin
                emit_event(EV_DOCSTART, 0, 0, 1'b0);
                doc_st = DOC_RUN;
            end
            else
            begin
                emit_event(EV_NOTUNI, 0, 0, 1'b0);
                doc_st = DOC_REJECT;
            end
            return;
        end
        if (doc_st != DOC_RUN)
            return;
        if (eod)
        begin
            emit_event(EV_DOCEND, 0, 0, 1'b0);
            clear_tokens();
            doc_st = DOC_DONE;
            return;
        end
        if (c < 16'h0020)
            return;
        case (mode)
            MODE_ESTART: element_start(c);
            MODE_ANAME:
            begin
                if (c == CH_EQ)
                begin
                    value_len = 0;
                    quote_open = 1'b0;
                    mode = MODE_AVALUE;
                end
                else if (c == CH_GT)
                begin
                    clear_tokens();
                    mode = MODE_TEXT;
                end
                else if (c != CH_SPACE)
                    keep_name(c);
            end
            MODE_AVALUE:
            begin
                if (!quote_open)
                    quote_open = (c == CH_QUOTE);
                else if (c == CH_QUOTE)
                begin
                    emit_event(EV_ATTR, name_len, value_len, 1'b0);
                    clear_tokens();
                    mode = MODE_ANAME;
                end
                else
                    keep_value(c);
            end
            MODE_EEND:
            begin
                if (c == CH_GT)
                begin
                    if (name_len > 0)
                        emit_event(EV_EEND, name_len, 0, 1'b0);
                    clear_tokens();
                    mode = MODE_TEXT;
                end
                else if (c != CH_SPACE)
                    keep_name(c);
            end
            default:
            begin
                if (prev_ch == CH_LT)
                begin
                    if (c != CH_SLASH)
                    begin
                        if (value_len > 0)
                            emit_event(EV_FMT, value_len, 0, 1'b1);
                        clear_tokens();
                        mode = MODE_ESTART;
                        element_start(c);
                    end
                    else
                    begin
                        if (value_len > 0)
                            emit_event(EV_TEXT, value_len, 0, 1'b1);
                        clear_tokens();
                        mode = MODE_EEND;
                    end
                end
                else if (c == CH_LT)
                    prev_ch = c;
                else
                    keep_value(c);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        event_word_t exp_w;
        if (!rst_n)
        begin
            expected_words.delete();
            marker = MARKER_RESET;
            doc_st = DOC_AWAIT;
            mode = MODE_TEXT;
            clear_tokens();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: kind %0d char %h present %b part %b last %b",
                                 event_kind, char_value, char_present, char_part,
                                 last_of_event);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.kind !== event_kind || exp_w.ch !== char_value ||
                        exp_w.present !== char_present || exp_w.part !== char_part ||
                        exp_w.last !== last_of_event)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %0d/%h/%b/%b/%b got %0d/%h/%b/%b/%b",
                                     exp_w.kind, exp_w.ch, exp_w.present, exp_w.part,
                                     exp_w.last, event_kind, char_value, char_present,
                                     char_part, last_of_event);
                    end
                end
            end
            if (in_valid && !in_stall)
                tokenize(code_unit, end_of_document);
            if (psel && penable && pwrite && pready && paddr == REG_MARKER)
                marker = pwdata[15:0];
            pending = expected_words.size();
        end
    end

endmodule

@@ dv/tb_xml_event_tokenizer.sv @@
// testbench top: stimulus, idling, watchdog and verdict for the xml event tokenizer
`timescale 1ns / 1ps
module tb_xml_event_tokenizer;
    import xet_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] code_unit = '0;
    logic        end_of_document = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_kind;
    logic [15:0] char_value;
    logic        char_present;
    logic        char_part;
    logic        last_of_event;
    int          fail_count;
    int          pending;

    int send_idle_pct = 16;
    int rx_stall_pct = 76;
    int phase = 0;
    int items_sent = 0;
    int hold_cnt = 0;
    bit held = 1'b0;
    int quiet_cycles = 0;

    always #2 clk = ~clk;

    xml_event_tokenizer u_dut (.*);

    xet_checker u_checker (.*);

    // receiver stall, with one long hold-off in the last phase
    always @(negedge clk)
    begin
        if (phase == 2 && !held && items_sent > 2 * PHASE_ITEMS + 20)
        begin
            held = 1'b1;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_word(logic [15:0] c, logic eod);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        code_unit <= c;
        end_of_document <= eod;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    function automatic logic [15:0] name_char();
        return 16'h0061 + 16'($urandom_range(25));
    endfunction

    function automatic logic [15:0] any_char();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return name_char();
        else if (r < 70)
            return 16'($urandom_range(31));
        else
            return 16'($urandom_range(65535));
    endfunction

    task automatic send_name(int len);
        for (int i = 0; i < len; i++)
            send_word(name_char(), 1'b0);
    endtask

    task automatic send_element();
        int nlen;
        int nattr;
        int r;
        logic [15:0] nm[$];
        r = $urandom_range(99);
        if (r < 10)
        begin
            // noise
            repeat ($urandom_range(8, 1))
                send_word(any_char(), 1'b0);
            return;
        end
        nlen = ($urandom_range(19) == 0) ? $urandom_range(40, 33) : $urandom_range(6, 1);
        send_word(CH_LT, 1'b0);
        for (int i = 0; i < nlen; i++)
        begin
            nm.push_back(name_char());
            send_word(nm[i], 1'b0);
        end
        nattr = $urandom_range(2);
        for (int a = 0; a < nattr; a++)
        begin
            send_word(CH_SPACE, 1'b0);
            send_name($urandom_range(4, 1));
            send_word(CH_EQ, 1'b0);
            send_word(CH_QUOTE, 1'b0);
            repeat (($urandom_range(19) == 0) ? 36 : $urandom_range(4))
                send_word(any_char(), 1'b0);
            send_word(CH_QUOTE, 1'b0);
        end
        if ($urandom_range(3) == 0)
        begin
            send_word(CH_SLASH, 1'b0);
            send_word(CH_GT, 1'b0);
            return;
        end
        send_word(CH_GT, 1'b0);
        repeat ($urandom_range(6))
            send_word(any_char(), 1'b0);
        send_word(CH_LT, 1'b0);
        send_word(CH_SLASH, 1'b0);
        if ($urandom_range(4) != 0)
            for (int i = 0; i < nm.size(); i++)
                send_word(nm[i], 1'b0);
        send_word(CH_GT, 1'b0);
    endtask

    task automatic settle();
        while (pending != 0)
            @(posedge clk);
        repeat (6)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        string directed;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        reg_write(REG_MARKER, 32'h0000_0000);
        reg_write(REG_MARKER, 32'hFFFF_FFFF);
        reg_write(REG_MARKER, {16'h0, MARKER_RESET});
        send_word(MARKER_RESET, 1'b0);
        directed = "<a>hi</a><bc/>x<c k=\"v\" z=\"\">t</c></>< d>w<>";
        for (int i = 0; i < directed.len(); i++)
            send_word(16'(directed[i]), 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        while (items_sent < PHASE_ITEMS)
            send_element();
        in_valid <= 1'b0;
        settle();
        reg_write(REG_MARKER, 32'h0000_1234);
        send_idle_pct = 76;
        rx_stall_pct = 16;
        phase = 1;
        while (items_sent < 2 * PHASE_ITEMS)
            send_element();
        in_valid <= 1'b0;
        settle();
        reg_write(REG_MARKER, 32'h0000_FFFF);
        send_idle_pct = 0;
        rx_stall_pct = 0;
        phase = 2;
        while (items_sent < 3 * PHASE_ITEMS + 10)
            send_element();
        send_word(16'h0000, 1'b1);
        send_word(CH_LT, 1'b0);
        send_word(16'h0000, 1'b1);
        in_valid <= 1'b0;
        end_of_document <= 1'b0;
        settle();
        repeat (20)
            @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ xml_event_tokenizer.f @@
+incdir+hdl
hdl/xet_pkg.sv
hdl/xet_ram.sv
hdl/xet_datapath.sv
hdl/xet_controller.sv
hdl/xml_event_tokenizer.sv
hdl/xet_checker.sv
dv/xet_checker.sv
dv/tb_xml_event_tokenizer.sv
